// ----- src/fsk4_pkg.sv -----
// Shared constants, register codes and sine table functions for the 4-FSK modulator.
package fsk4_pkg;

  localparam int PHASE_BITS_DEF      = 24;
  localparam int TABLE_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int CFG_STEP_BITS = 24;
  localparam int CFG_SPS_BITS  = 7;
  localparam int CFG_AMP_BITS  = 15;
  localparam int CFG_DATA_BITS = 24;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_STEP    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPACING_STEP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPS          = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_AMPLITUDE    = 2'd3;

  localparam logic [CFG_STEP_BITS-1:0] BASE_STEP_RST    = '0;
  localparam logic [CFG_STEP_BITS-1:0] SPACING_STEP_RST = '0;
  localparam logic [CFG_SPS_BITS-1:0]  SPS_RST          = 7'd16;
  localparam logic [CFG_AMP_BITS-1:0]  AMPLITUDE_RST    = 15'd16384;

  localparam int SPS_MAX  = 64;
  localparam int CNT_BITS = $clog2(SPS_MAX);

  localparam int ROM_WIDTH = 16;
  localparam int PROD_BITS = 32;
  localparam int ROM_SHIFT = 15;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd1 << 29;
  localparam logic [63:0] SINE_PEAK   = 64'd32767;

  // shift-subtract quotient, only evaluated while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = {r[62:0], num[bi]};
      if (r >= den) begin
        r     = r - den;
        q[bi] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(32767 * sin(pi/2 * m / 2^qshift)), Q30 Taylor series
  function automatic logic [ROM_WIDTH-1:0] quarter_sine(input logic [63:0] m,
                                                        input int unsigned qshift);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (m * HALF_PI_Q30) >> qshift;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n < 16; n++) begin
      if (term != 64'd0) begin
        term = (term * x2) >> 30;
        term = udiv64(term, 64'(2 * n) * 64'(2 * n + 1));
        if (n[0]) sum = sum - $signed(term);
        else      sum = sum + $signed(term);
      end
    end
    if (sum < 0) sum = '0;
    v = ($unsigned(sum) * SINE_PEAK + Q30_HALF) >> 30;
    if (v > SINE_PEAK) v = SINE_PEAK;
    return v[ROM_WIDTH-1:0];
  endfunction

  function automatic logic [ROM_WIDTH-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned tab_bits);
    int unsigned          qshift;
    int unsigned          quarter;
    int unsigned          quad;
    int unsigned          m;
    logic [ROM_WIDTH-1:0] v;
    qshift  = tab_bits - 2;
    quarter = 1 << qshift;
    quad    = k >> qshift;
    m       = k & (quarter - 1);
    if (quad[0]) v = quarter_sine(64'(quarter - m), qshift);
    else         v = quarter_sine(64'(m), qshift);
    if (quad[1]) v = -v;
    return v;
  endfunction

endpackage

// ----- src/fsk4_sym_if.sv -----
// Symbol input channel: valid/ready with symbol and frame-start payload.
interface fsk4_sym_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol;
  logic       frame_start;

  modport source (output valid, output symbol, output frame_start, input ready);
  modport sink   (input valid, input symbol, input frame_start, output ready);
endinterface

// ----- src/fsk4_smp_if.sv -----
// Sample output channel: valid/ready with signed sample and end-of-symbol flag.
interface fsk4_smp_if
  import fsk4_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last_of_symbol;

  modport source (output valid, output sample, output last_of_symbol, input ready);
  modport sink   (input valid, input sample, input last_of_symbol, output ready);
endinterface

// ----- src/fsk4_tone_modulator.sv -----
// Top level: continuous-phase 4-FSK modulator with NCO, sine ROM and scaler.
//
// Each accepted symbol produces the configured number of samples (0 counts as 1,
// values above 64 count as 64), one per clock while the output is taken; the next
// symbol is taken in the cycle its predecessor's last phase is issued, giving a
// gapless stream. The rate is set by the phase accumulator, which issues one ROM
// address per cycle while the output is taken. A sample passes the ROM read,
// multiply and output registers after its phase is issued. frame_start clears
// the phase before the symbol's first sample. Configuration is written through
// cfg_we/cfg_index/cfg_wdata; the user must write it only while idle, which the
// block itself does not enforce; the ROM is constant and needs no fill after reset.
module fsk4_tone_modulator
  import fsk4_pkg::*;
#(
  parameter int PHASE_BITS      = PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  fsk4_sym_if.sink                 in_ch,
  fsk4_smp_if.source               out_ch
);

  localparam int SW = ((PHASE_BITS > CFG_STEP_BITS) ? PHASE_BITS : CFG_STEP_BITS) + 2;
  localparam logic signed [PROD_BITS-1:0] SAT_HI =
    (PROD_BITS'(1) <<< (SAMPLE_BITS - 1)) - PROD_BITS'(1);
  localparam logic signed [PROD_BITS-1:0] SAT_LO = -SAT_HI - PROD_BITS'(1);

  // configuration registers
  logic [CFG_STEP_BITS-1:0] base_r;
  logic [CFG_STEP_BITS-1:0] spacing_r;
  logic [CFG_SPS_BITS-1:0]  sps_r;
  logic [CFG_AMP_BITS-1:0]  amp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= BASE_STEP_RST;
      spacing_r <= SPACING_STEP_RST;
      sps_r     <= SPS_RST;
      amp_r     <= AMPLITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_STEP:    base_r    <= cfg_wdata[CFG_STEP_BITS-1:0];
        REG_SPACING_STEP: spacing_r <= cfg_wdata[CFG_STEP_BITS-1:0];
        REG_SPS:          sps_r     <= cfg_wdata[CFG_SPS_BITS-1:0];
        REG_AMPLITUDE:    amp_r     <= cfg_wdata[CFG_AMP_BITS-1:0];
      endcase
    end
  end

  // phase sequencer
  logic                  busy_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic [CNT_BITS-1:0]   last_idx_r;
  logic [CNT_BITS-1:0]   last_idx_nxt;
  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_adv;
  logic [PHASE_BITS-1:0] step_r;
  logic [PHASE_BITS-1:0] step_nxt;
  logic [SW-1:0]         step_sum;
  logic                  adv;
  logic                  issue;
  logic                  is_last;
  logic                  in_fire;
  logic                  out_valid_r;

  assign adv       = !out_valid_r || out_ch.ready;
  assign issue     = busy_r && adv;
  assign is_last   = (cnt_r == last_idx_r);
  assign in_ch.ready = !busy_r || (adv && is_last);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign phase_adv = phase_r + step_r;

  assign step_sum = SW'(base_r)
                  + (in_ch.symbol[0] ? SW'(spacing_r) : '0)
                  + (in_ch.symbol[1] ? (SW'(spacing_r) << 1) : '0);
  assign step_nxt = step_sum[PHASE_BITS-1:0];

  always_comb begin
    if (sps_r == '0) begin
      last_idx_nxt = '0;
    end else if (sps_r > CFG_SPS_BITS'(SPS_MAX)) begin
      last_idx_nxt = CNT_BITS'(SPS_MAX - 1);
    end else begin
      last_idx_nxt = CNT_BITS'(sps_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      phase_r <= '0;
    end else if (in_fire) begin
      busy_r  <= 1'b1;
      cnt_r   <= '0;
      phase_r <= in_ch.frame_start ? '0 : (issue ? phase_adv : phase_r);
    end else if (issue) begin
      phase_r <= phase_adv;
      if (is_last) busy_r <= 1'b0;
      else         cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_r     <= step_nxt;
      last_idx_r <= last_idx_nxt;
    end
  end

  // ROM address from the top phase bits
  logic [TABLE_ADDR_BITS-1:0] rom_addr;

  if (PHASE_BITS >= TABLE_ADDR_BITS) begin : g_idx_hi
    assign rom_addr = phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  end else begin : g_idx_lo
    assign rom_addr = {phase_r, {(TABLE_ADDR_BITS - PHASE_BITS){1'b0}}};
  end

  logic signed [ROM_WIDTH-1:0] rom_data;

  fsk4_sine_rom #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (adv),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  // scaling pipeline
  logic                          v1_r;
  logic                          last1_r;
  logic                          v2_r;
  logic                          last2_r;
  logic signed [PROD_BITS-1:0]   prod_r;
  logic signed [PROD_BITS-1:0]   prod_nxt;
  logic signed [PROD_BITS-1:0]   shifted;
  logic signed [PROD_BITS-1:0]   sat;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          last_r;

  assign prod_nxt = PROD_BITS'($signed({1'b0, amp_r})) * PROD_BITS'(rom_data);
  assign shifted  = prod_r >>> ROM_SHIFT;

  always_comb begin
    if (shifted > SAT_HI)      sat = SAT_HI;
    else if (shifted < SAT_LO) sat = SAT_LO;
    else                       sat = shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= issue;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last1_r  <= is_last;
      last2_r  <= last1_r;
      prod_r   <= prod_nxt;
      last_r   <= last2_r;
      sample_r <= sat[SAMPLE_BITS-1:0];
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample         = sample_r;
  assign out_ch.last_of_symbol = last_r;

  // a new symbol only arrives while the previous one issues its last phase
  a_accept_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && busy_r) |-> (issue && is_last))
    else $error("symbol accepted mid-symbol");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= last_idx_r))
    else $error("sample counter past last index");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && is_last && !in_fire) |=> !busy_r)
    else $error("sequencer busy after last sample");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && !is_last) |=> (busy_r && cnt_r == $past(cnt_r) + 1'b1))
    else $error("sample counter did not advance");

endmodule

// ----- src/fsk4_sine_rom.sv -----
// Full-wave Q1.15 sine ROM with registered read.
module fsk4_sine_rom
  import fsk4_pkg::*;
#(
  parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [TABLE_ADDR_BITS-1:0]  addr,
  output logic signed [ROM_WIDTH-1:0] data_r
);

  localparam int ROM_SIZE = 1 << TABLE_ADDR_BITS;

  function automatic logic [ROM_SIZE-1:0][ROM_WIDTH-1:0] build_table();
    logic [ROM_SIZE-1:0][ROM_WIDTH-1:0] t;
    for (int k = 0; k < ROM_SIZE; k++) begin
      t[k] = sine_entry(k, TABLE_ADDR_BITS);
    end
    return t;
  endfunction

  localparam logic [ROM_SIZE-1:0][ROM_WIDTH-1:0] ROM_TABLE = build_table();

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= $signed(ROM_TABLE[addr]);
    end
  end

endmodule

// ----- tb/sv/fsk4_tone_modulator_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the 4-FSK tone modulator: predicted sample stream vs. DUT.
module fsk4_tone_modulator_tb;
  import fsk4_pkg::*;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUARTER       = 1 << (TABLE_ADDR_BITS_DEF - 2);
  localparam int LUT_SIZE      = 1 << TABLE_ADDR_BITS_DEF;
  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct {
    logic signed [SAMPLE_BITS_DEF-1:0] smp;
    logic                              eos;
  } tone_sample_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  fsk4_sym_if sym_ch ();
  fsk4_smp_if smp_ch ();

  fsk4_tone_modulator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (sym_ch),
    .out_ch   (smp_ch)
  );

  int                        sine_lut [LUT_SIZE];
  logic [PHASE_BITS_DEF-1:0] tone_phase;
  logic [PHASE_BITS_DEF-1:0] tone_base;
  logic [PHASE_BITS_DEF-1:0] tone_spacing;
  int                        tone_sps;
  int                        tone_amp;
  tone_sample_t              samples_due [$];
  tone_sample_t              oldest_due;

  bit src_gaps      = 1'b1;
  bit snk_stalls    = 1'b1;
  int stall_left    = 0;
  int cycles        = 0;
  int errors        = 0;
  int symbols_sent  = 0;
  int samples_seen  = 0;
  int settings_used = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Q30 Taylor series, one quarter wave, rounded to Q1.15
  function automatic int quarter_wave(input longint unsigned m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    x    = (m * QUARTER_TURN_Q30) >> (TABLE_ADDR_BITS_DEF - 2);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n < 16 && term != 0; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else            acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    mag = (64'(acc) * 64'd32767 + 64'd536870912) >> 30;
    return (mag > 64'd32767) ? 32767 : int'(mag);
  endfunction

  initial begin : fill_sine
    int mag;
    for (int k = 0; k < LUT_SIZE; k++) begin
      if ((k / QUARTER) % 2 == 1) mag = quarter_wave(QUARTER - (k % QUARTER));
      else                        mag = quarter_wave(k % QUARTER);
      sine_lut[k] = ((k / (2 * QUARTER)) % 2 == 1) ? -mag : mag;
    end
  end

  task automatic predict_symbol(input logic [1:0] sym, input logic fs);
    logic [PHASE_BITS_DEF-1:0] step;
    int                        n;
    int                        prod;
    tone_sample_t              s;
    if (fs) tone_phase = '0;
    step = tone_base + sym * tone_spacing;
    n = (tone_sps == 0) ? 1 : ((tone_sps > SPS_MAX) ? SPS_MAX : tone_sps);
    for (int i = 0; i < n; i++) begin
      prod  = tone_amp * sine_lut[tone_phase[PHASE_BITS_DEF-1 -: TABLE_ADDR_BITS_DEF]];
      s.smp = SAMPLE_BITS_DEF'(prod >>> 15);
      s.eos = (i == n - 1);
      samples_due = {samples_due, s};
      tone_phase = tone_phase + step;
    end
  endtask

  task automatic send_symbol(input logic [1:0] sym, input logic fs);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      sym_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    sym_ch.valid       <= 1'b1;
    sym_ch.symbol      <= sym;
    sym_ch.frame_start <= fs;
    do @(posedge clk); while (sym_ch.ready !== 1'b1);
    predict_symbol(sym, fs);
    symbols_sent++;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    sym_ch.valid <= 1'b0;
    while (samples_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic drive_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_BASE_STEP:    tone_base    = data[CFG_STEP_BITS-1:0];
      REG_SPACING_STEP: tone_spacing = data[CFG_STEP_BITS-1:0];
      REG_SPS:          tone_sps     = int'(data[CFG_SPS_BITS-1:0]);
      REG_AMPLITUDE:    tone_amp     = int'(data[CFG_AMP_BITS-1:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_config(input logic [CFG_DATA_BITS-1:0] base, spacing, sps_raw, amp_raw);
    settle_idle();
    drive_reg(REG_BASE_STEP, base);
    drive_reg(REG_SPACING_STEP, spacing);
    drive_reg(REG_SPS, sps_raw);
    drive_reg(REG_AMPLITUDE, amp_raw);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // zero steps after reset: flat output, 16 samples per symbol
  task automatic test_reset_defaults();
    send_symbol(2'd3, 1'b0);
    send_symbol(2'd0, 1'b1);
  endtask

  task automatic test_tone_select();
    load_config(24'h020000, 24'h010000, 24'd8, 24'd32767);
    send_symbol(2'd0, 1'b1);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd2, 1'b0);
    send_symbol(2'd3, 1'b0);
    send_symbol(2'd2, 1'b1);
  endtask

  // full-scale steps wrap; high bits of narrow registers dropped
  task automatic test_step_wrap();
    load_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_symbol(2'd3, 1'b0);
    send_symbol(2'd1, 1'b1);
  endtask

  task automatic test_sps_limits();
    load_config(24'h123457, 24'h0F0F0F, 24'hFFFF80, 24'h000000);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd3, 1'b1);
    send_symbol(2'd2, 1'b0);
    load_config(24'h400000, 24'h000000, 24'hABCDC1, 24'hFF8001);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd2, 1'b1);
    // quarter-turn base steps land symbol 0 on the sine peaks and zero crossings
    load_config(24'h400000, 24'h200000, 24'd1, 24'h007FFF);
    send_symbol(2'd0, 1'b1);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd3, 1'b0);
    send_symbol(2'd2, 1'b0);
  endtask

  task automatic test_random_settings(input int phases);
    logic [CFG_DATA_BITS-1:0] base;
    logic [CFG_DATA_BITS-1:0] spacing;
    int                       sps;
    int                       amp;
    int                       items;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0:       base = '0;
        1:       base = '1;
        default: base = 24'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       spacing = '0;
        1:       spacing = '1;
        default: spacing = 24'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       sps = SPS_MAX;
        1:       sps = $urandom_range(SPS_MAX + 1, 127);
        2:       sps = 0;
        default: sps = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 5))
        0:       amp = 0;
        1:       amp = 32767;
        default: amp = $urandom_range(1, 32766);
      endcase
      load_config(base, spacing, {17'($urandom), 7'(sps)}, {9'($urandom), 15'(amp)});
      src_gaps   = ($urandom_range(0, 3) != 0);
      snk_stalls = ($urandom_range(0, 3) != 0);
      items = $urandom_range(8, 24);
      repeat (items) send_symbol(2'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  // no idling on either side: symbols are offered without gaps
  task automatic test_back_to_back();
    src_gaps   = 1'b0;
    snk_stalls = 1'b0;
    load_config(24'($urandom), 24'($urandom), 24'd3, 24'd30000);
    repeat (20) send_symbol(2'($urandom), $urandom_range(0, 7) == 0);
    load_config(24'($urandom), 24'($urandom), 24'd1, 24'd32767);
    repeat (20) send_symbol(2'($urandom), $urandom_range(0, 7) == 0);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      smp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (snk_stalls && $urandom_range(0, 5) == 0) begin
      smp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 6);
    end else begin
      smp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && smp_ch.valid === 1'b1 && smp_ch.ready === 1'b1) begin
      samples_seen++;
      if (samples_due.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected sample, expected none, actual %0d last %0b",
                   $time, smp_ch.sample, smp_ch.last_of_symbol);
      end else begin
        oldest_due = samples_due.pop_front();
        if (smp_ch.sample !== oldest_due.smp || smp_ch.last_of_symbol !== oldest_due.eos) begin
          errors++;
          if (errors <= 20)
            $display("%0t: sample mismatch, expected %0d last %0b, actual %0d last %0b",
                     $time, oldest_due.smp, oldest_due.eos,
                     smp_ch.sample, smp_ch.last_of_symbol);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d samples outstanding",
               cycles, samples_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_BASE_STEP;
    cfg_wdata          = '0;
    sym_ch.valid       = 1'b0;
    sym_ch.symbol      = 2'd0;
    sym_ch.frame_start = 1'b0;
    smp_ch.ready       = 1'b0;
    tone_phase         = '0;
    tone_base          = BASE_STEP_RST;
    tone_spacing       = SPACING_STEP_RST;
    tone_sps           = int'(SPS_RST);
    tone_amp           = int'(AMPLITUDE_RST);
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_tone_select();
    test_step_wrap();
    test_sps_limits();
    test_random_settings(18);
    test_back_to_back();
    settle_idle();

    $display("Covered %0d symbols and %0d checked samples over %0d register settings,",
             symbols_sent, samples_seen, settings_used);
    $display("with 1 to 64 samples per symbol, zero and full amplitude, wrapped steps.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/fsk4_pkg.sv
src/fsk4_sym_if.sv
src/fsk4_smp_if.sv
src/fsk4_sine_rom.sv
src/fsk4_tone_modulator.sv
tb/sv/fsk4_tone_modulator_tb.sv
